// ----- rtl/scci_pkg.sv -----
// Shared types and constants for the serial calendar-clock interface.
package scci_pkg;

    typedef enum logic [1:0] {
        ACT_CMD_WRITE    = 2'd0,
        ACT_STROBE_WRITE = 2'd1,
        ACT_READ         = 2'd2,
        ACT_RESET        = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] read_mask;
    } t_out_word;

    localparam logic [3:0] CMD_HOLD      = 4'd0;
    localparam logic [3:0] CMD_SHIFT     = 4'd1;
    localparam logic [3:0] CMD_TIME_SET  = 4'd2;
    localparam logic [3:0] CMD_TIME_READ = 4'd3;

    localparam logic [2:0] CODE_EXTENDED = 3'd7;

    localparam logic [7:0] READ_MASK = 8'h10;

    localparam int unsigned TIME_W  = 48;
    localparam int unsigned SHORT_W = 40;

    localparam int unsigned BIT_DIN    = 3;
    localparam int unsigned BIT_STROBE = 1;
    localparam int unsigned BIT_CLOCK  = 2;
    localparam int unsigned BIT_DOUT   = 4;

endpackage

// ----- rtl/scci_core.sv -----
// Clock chip state and the per-word update logic.
module scci_core
    import scci_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    logic [7:0]        r_port_prev,   n_port_prev;
    logic [2:0]        r_pend_code,   n_pend_code;
    logic              r_din,         n_din;
    logic              r_ext,         n_ext;
    logic [3:0]        r_active,      n_active;
    logic [3:0]        r_serial_cmd,  n_serial_cmd;
    logic [TIME_W-1:0] r_chain,       n_chain;
    logic              r_hold,        n_hold;
    logic              r_oe,          n_oe;
    logic [TIME_W-1:0] r_stored,      n_stored;

    always_comb begin
        logic [7:0] rise;
        n_port_prev  = r_port_prev;
        n_pend_code  = r_pend_code;
        n_din        = r_din;
        n_ext        = r_ext;
        n_active     = r_active;
        n_serial_cmd = r_serial_cmd;
        n_chain      = r_chain;
        n_hold       = r_hold;
        n_oe         = r_oe;
        n_stored     = r_stored;
        o_result     = '0;
        rise         = (r_port_prev ^ i_word.data) & i_word.data;

        unique case (i_word.action)
            ACT_CMD_WRITE: begin
                n_pend_code = i_word.data[2:0];
                n_din       = i_word.data[BIT_DIN];
            end
            ACT_STROBE_WRITE: begin
                n_port_prev = i_word.data;
                // strobe command first, then the clock shift sees its result
                if (rise[BIT_STROBE]) begin
                    if (r_pend_code == CODE_EXTENDED) begin
                        n_ext    = 1'b1;
                        n_active = r_serial_cmd;
                    end else begin
                        n_ext    = 1'b0;
                        n_active = {1'b0, r_pend_code};
                    end
                    unique case (n_active)
                        CMD_HOLD: begin
                            n_hold = 1'b1;
                            n_oe   = 1'b0;
                        end
                        CMD_SHIFT: begin
                            n_hold = 1'b0;
                            n_oe   = 1'b1;
                        end
                        CMD_TIME_SET: begin
                            if (n_ext) begin
                                n_stored = r_chain;
                            end else begin
                                n_stored[SHORT_W-1:0] = r_chain[SHORT_W-1:0];
                            end
                            n_hold = 1'b1;
                            n_oe   = 1'b1;
                        end
                        CMD_TIME_READ: begin
                            n_chain = r_stored;
                            n_hold  = 1'b1;
                            n_oe    = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                if (rise[BIT_CLOCK]) begin
                    if (n_hold) begin
                        if (n_ext) begin
                            n_serial_cmd = {r_din, r_serial_cmd[3:1]};
                        end
                    end else if (n_ext) begin
                        n_chain      = {r_serial_cmd[0], n_chain[TIME_W-1:1]};
                        n_serial_cmd = {r_din, r_serial_cmd[3:1]};
                    end else begin
                        // year byte stays put in the short chain
                        n_chain[SHORT_W-1:0] = {r_din, n_chain[SHORT_W-1:1]};
                    end
                end
            end
            ACT_READ: begin
                o_result.read_mask = READ_MASK;
                o_result.read_data[BIT_DOUT] = r_oe & r_chain[0];
            end
            ACT_RESET: begin
                n_din        = 1'b0;
                n_oe         = 1'b0;
                n_port_prev  = '0;
                n_ext        = 1'b1;
                n_active     = CMD_HOLD;
                n_serial_cmd = '0;
                n_chain      = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_prev  <= '0;
            r_pend_code  <= '0;
            r_din        <= 1'b0;
            r_ext        <= 1'b1;
            r_active     <= '0;
            r_serial_cmd <= '0;
            r_chain      <= '0;
            r_hold       <= 1'b0;
            r_oe         <= 1'b0;
            r_stored     <= '0;
        end else if (i_fire) begin
            r_port_prev  <= n_port_prev;
            r_pend_code  <= n_pend_code;
            r_din        <= n_din;
            r_ext        <= n_ext;
            r_active     <= n_active;
            r_serial_cmd <= n_serial_cmd;
            r_chain      <= n_chain;
            r_hold       <= n_hold;
            r_oe         <= n_oe;
            r_stored     <= n_stored;
        end
    end

endmodule

// ----- rtl/serial_calendar_clock_interface_top.sv -----
// Top level of the serial calendar-clock interface: input and result registers.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one bus access
//   per word: command/data port write, strobe/clock port write, data-out read,
//   or interface reset. Output channel (o_out_valid / i_out_stall /
//   o_out_word) returns exactly one result word per input word, in order.
//   Non-read accesses return zero data and zero mask; reads return mask 0x10
//   and the data-out bit in bit 4.
//   Path: from input accept the word sits in the input register, and the
//   update logic feeds the result register from it.
//   Throughput: one word per cycle while i_out_stall is low; the single-pass
//   update of the chip state sits between the input and result registers.
//   Stall: while the result register is held by i_out_stall, the input
//   register keeps its word and o_in_stall rises once it is occupied; the
//   chip state only advances when a word moves into the result register.
//   Reset (i_rst_n low, synchronous): both registers empty, all chip state
//   to its power-up values (extended mode set, everything else clear).
module serial_calendar_clock_interface_top
    import scci_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      advance;
    logic      fire;

    // result register free or draining this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    scci_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // only the data-out bit may ever be driven
    a_data_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.read_data & ~READ_MASK) == 8'h00))
        else $error("read data outside data-out bit");

    // data present only on reads
    a_data_on_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.read_mask == 8'h00)) |-> (o_out_word.read_data == 8'h00))
        else $error("read data on non-read word");

    // a word blocked at the input means one is parked in the input register
    a_stall_holds_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stall without a parked word");

    // a result cannot appear without a word having been registered before
    a_out_from_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result without input word");

endmodule

// ----- tb/calendar_access_checker.sv -----
// Checker for the serial calendar-clock interface: predicts each result word and compares.
`timescale 1ns / 1ps

module calendar_access_checker
    import scci_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_outstanding
);

    // predicted chip state
    logic [7:0]        last_lines;
    logic [2:0]        latched_code;
    logic              din_level;
    logic              ext_mode;
    logic [3:0]        running_cmd;
    logic [3:0]        serial_cmd;
    logic [TIME_W-1:0] chain;
    logic              held;
    logic              dout_en;
    logic [TIME_W-1:0] clock_time;

    t_out_word expected_replies[$];
    t_out_word want;
    t_out_word next_reply;
    int        fails = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // interface reset: hold flag, latched code and stored time survive
    task automatic clear_interface();
        din_level   = 1'b0;
        dout_en     = 1'b0;
        last_lines  = '0;
        ext_mode    = 1'b1;
        running_cmd = CMD_HOLD;
        serial_cmd  = '0;
        chain       = '0;
    endtask

    task automatic advance_calendar(input t_in_word w, output t_out_word reply);
        logic [7:0] rise;
        reply = '0;
        case (w.action)
            ACT_CMD_WRITE: begin
                latched_code = w.data[2:0];
                din_level    = w.data[BIT_DIN];
            end
            ACT_STROBE_WRITE: begin
                rise       = (last_lines ^ w.data) & w.data;
                last_lines = w.data;
                // strobe runs before the clock when both rise together
                if (rise[BIT_STROBE]) begin
                    if (latched_code == CODE_EXTENDED) begin
                        ext_mode    = 1'b1;
                        running_cmd = serial_cmd;
                    end else begin
                        ext_mode    = 1'b0;
                        running_cmd = {1'b0, latched_code};
                    end
                    case (running_cmd)
                        CMD_HOLD: begin
                            held    = 1'b1;
                            dout_en = 1'b0;
                        end
                        CMD_SHIFT: begin
                            held    = 1'b0;
                            dout_en = 1'b1;
                        end
                        CMD_TIME_SET: begin
                            if (ext_mode)
                                clock_time = chain;
                            else
                                clock_time[SHORT_W-1:0] = chain[SHORT_W-1:0];
                            held    = 1'b1;
                            dout_en = 1'b1;
                        end
                        CMD_TIME_READ: begin
                            chain   = clock_time;
                            held    = 1'b1;
                            dout_en = 1'b0;
                        end
                        default: ;
                    endcase
                end
                if (rise[BIT_CLOCK]) begin
                    if (held) begin
                        if (ext_mode)
                            serial_cmd = {din_level, serial_cmd[3:1]};
                    end else if (ext_mode) begin
                        chain      = {serial_cmd[0], chain[TIME_W-1:1]};
                        serial_cmd = {din_level, serial_cmd[3:1]};
                    end else begin
                        // year byte stays put in normal mode
                        chain[SHORT_W-1:0] = {din_level, chain[SHORT_W-1:1]};
                    end
                end
            end
            ACT_READ: begin
                reply.read_mask = READ_MASK;
                if (dout_en)
                    reply.read_data[BIT_DOUT] = chain[0];
            end
            ACT_RESET: clear_interface();
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_interface();
            latched_code = '0;
            held         = 1'b0;
            clock_time   = '0;
            expected_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("result word with nothing outstanding: read_data %h read_mask %h",
                           i_out_word.read_data, i_out_word.read_mask);
                    fails++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_out_word.read_data !== want.read_data) begin
                        $error("read_data expected %h got %h",
                               want.read_data, i_out_word.read_data);
                        fails++;
                    end
                    if (i_out_word.read_mask !== want.read_mask) begin
                        $error("read_mask expected %h got %h",
                               want.read_mask, i_out_word.read_mask);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_calendar(i_in_word, next_reply);
                expected_replies.push_back(next_reply);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_replies.size();
    end

endmodule

// ----- tb/serial_calendar_clock_interface_top_test.sv -----
// Testbench top for the serial calendar-clock interface: stimulus, idling and verdict.
`timescale 1ns / 1ps

module serial_calendar_clock_interface_top_test;
    import scci_pkg::*;

    // random part stops once this many words went in
    localparam int WORD_TARGET = 850;
    // no word moving on either channel for this long means a hang
    localparam int IDLE_LIMIT  = 2000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int fail_count;
    int outstanding;

    int words_sent   = 0;
    int reads_sent   = 0;
    int results_seen = 0;
    int idle_cycles  = 0;

    // calm: no gaps and no stalls for the current stretch
    bit       calm = 1'b0;
    // what the command port currently holds in its code bits
    logic [2:0] cur_code = '0;

    serial_calendar_clock_interface_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    calendar_access_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Present one word, hold it until accepted, then maybe idle.
    // With no gap, valid stays high and the next call just swaps the word.
    task automatic send_word(input t_action act, input logic [7:0] data);
        int gap;
        i_in_valid       <= 1'b1;
        i_in_word.action <= act;
        i_in_word.data   <= data;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        if (act == ACT_READ)
            reads_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Command/data port: code in bits 0-2, data in at bit 3, top nibble is junk.
    task automatic put_code(input logic [2:0] code, input logic din);
        logic [7:0] d;
        d          = 8'($urandom);
        d[2:0]     = code;
        d[BIT_DIN] = din;
        cur_code   = code;
        send_word(ACT_CMD_WRITE, d);
    endtask

    // Strobe/clock port: only the two line bits matter, the rest is junk.
    task automatic put_lines(input logic stb, input logic clk);
        logic [7:0] d;
        d             = 8'($urandom);
        d[BIT_STROBE] = stb;
        d[BIT_CLOCK]  = clk;
        send_word(ACT_STROBE_WRITE, d);
    endtask

    task automatic read_dout();
        send_word(ACT_READ, 8'($urandom));
    endtask

    task automatic pulse_strobe(input logic [2:0] code);
        put_code(code, 1'($urandom));
        put_lines(1'b1, 1'b0);
        put_lines(1'b0, 1'b0);
    endtask

    // One clock pulse with a data-in bit, the data-out bit sampled now and then.
    task automatic clock_in(input logic din);
        put_code(cur_code, din);
        put_lines(1'b0, 1'b1);
        if ($urandom_range(0, 2) == 0)
            read_dout();
        put_lines(1'b0, 1'b0);
    endtask

    task automatic clock_random(input int nbits);
        for (int i = 0; i < nbits; i++)
            clock_in(1'($urandom));
    endtask

    // Extended mode: shift a command into the serial register, then strobe code 7.
    task automatic load_serial(input logic [3:0] cmd);
        for (int i = 0; i < 4; i++)
            clock_in(cmd[i]);
        pulse_strobe(CODE_EXTENDED);
    endtask

    // Normal mode: shift in 40 bits, set the time, read it back and shift it out.
    // Sometimes cut short to leave a broken sequence.
    task automatic normal_time_cycle();
        int nbits;
        nbits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SHORT_W - 1) : SHORT_W;
        pulse_strobe(3'(CMD_SHIFT));
        clock_random(nbits);
        pulse_strobe(3'(CMD_TIME_SET));
        pulse_strobe(3'(CMD_TIME_READ));
        pulse_strobe(3'(CMD_SHIFT));
        read_dout();
        clock_random($urandom_range(1, 12));
    endtask

    // Extended mode: full 48-bit time plus the serial command behind it.
    task automatic extended_time_cycle();
        int nbits;
        nbits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TIME_W - 1) : TIME_W;
        pulse_strobe(CODE_EXTENDED);
        load_serial(CMD_SHIFT);
        clock_random(nbits);
        load_serial(CMD_TIME_SET);
        load_serial(CMD_TIME_READ);
        load_serial(CMD_SHIFT);
        read_dout();
        clock_random($urandom_range(1, 12));
    endtask

    // Loose mix: any code, short shifts, reads, raw junk and the odd reset.
    task automatic random_phrase();
        int n;
        int r;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25)
                pulse_strobe(3'($urandom));
            else if (r < 45)
                clock_random($urandom_range(1, 6));
            else if (r < 60)
                read_dout();
            else if (r < 70)
                load_serial(4'($urandom));
            else if (r < 95)
                send_word(t_action'($urandom_range(0, 2)), 8'($urandom));
            else
                send_word(ACT_RESET, 8'($urandom));
        end
    endtask

    // Result side: free-running stretches broken by stalls of random length.
    initial begin : out_stall_gen
        int run_len;
        int hold_len;
        forever begin
            run_len = $urandom_range(1, 16);
            repeat (run_len) @(posedge i_clk);
            hold_len = pick_gap();
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            results_seen++;
    end

    // Watchdog: a run of cycles with no word moving either way ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset state, all-ones words, both lines rising at once,
        // every direct code but hold (code 0), the extended code, and the interface reset.
        calm = 1'b1;
        read_dout();
        send_word(ACT_CMD_WRITE, 8'hFF);        // code 7, data in high
        send_word(ACT_STROBE_WRITE, 8'hFF);     // strobe then clock in one write
        send_word(ACT_READ, 8'hFF);
        send_word(ACT_STROBE_WRITE, 8'h00);
        send_word(ACT_CMD_WRITE, 8'h09);        // shift, data in high
        send_word(ACT_STROBE_WRITE, 8'h06);     // start shift and clock together
        read_dout();
        send_word(ACT_STROBE_WRITE, 8'h00);
        send_word(ACT_CMD_WRITE, 8'h02);        // time set, year kept
        send_word(ACT_STROBE_WRITE, 8'h02);
        send_word(ACT_STROBE_WRITE, 8'h00);
        send_word(ACT_CMD_WRITE, 8'h03);        // time read
        send_word(ACT_STROBE_WRITE, 8'h02);
        read_dout();
        send_word(ACT_STROBE_WRITE, 8'h04);     // clock while held, normal mode
        send_word(ACT_STROBE_WRITE, 8'h00);
        for (int c = 4; c < 7; c++) begin       // codes with no effect
            send_word(ACT_CMD_WRITE, 8'(c));
            send_word(ACT_STROBE_WRITE, 8'h02);
            send_word(ACT_STROBE_WRITE, 8'h00);
        end
        send_word(ACT_RESET, 8'hFF);
        read_dout();
        send_word(ACT_RESET, 8'h00);

        // Random part: time set/read cycles with random content on under half of the picks,
        // the rest loose phrases that break sequences mid-way.
        while (words_sent < WORD_TARGET) begin
            calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                normal_time_cycle();
            else if (pick < 45)
                extended_time_cycle();
            else
                random_phrase();
        end

        i_in_valid <= 1'b0;
        calm = 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d result words for %0d bus accesses, %0d of them data-out reads.",
                 results_seen, words_sent, reads_sent);
        $display("Covered edge cases, normal and extended time set/read shifts and noise,");
        $display("under random gaps and stalls.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
